[rtl/vss_pkg.sv]
package vss_pkg;

    localparam int STEP_FRAC_BITS_DEF    = 8;
    localparam int POINT_COUNT_WIDTH_DEF = 16;

    localparam int CODE_W   = 12;
    localparam int STEP_W   = 20;
    localparam int BIAS_W   = 6;
    localparam int PPS_W    = 16;
    localparam int CYC_W    = 8;
    localparam int SCALE_W  = 24;
    localparam int SLOPE_W  = 9;
    localparam int SAMPLE_W = 16;
    localparam int WORD_W   = 18;
    localparam int CUR_W    = 40;
    localparam int ADDR_W   = 5;

    localparam logic [WORD_W-1:0]   ZERO_LEVEL_WORD = 18'h1F7BE;
    localparam logic [CODE_W-1:0]   CODE_MAX        = 12'd4095;
    localparam logic [SAMPLE_W:0]   ADC_MIDPOINT    = 17'd32768;
    localparam logic [SLOPE_W-1:0]  FIRST_SLOPE     = 9'd1;

    localparam logic MODE_START  = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        REG_LOW_CODE      = 3'd0,
        REG_HIGH_CODE     = 3'd1,
        REG_STEP_SIZE     = 3'd2,
        REG_BIAS_CODE     = 3'd3,
        REG_POINTS        = 3'd4,
        REG_CYCLE_COUNT   = 3'd5,
        REG_CURRENT_SCALE = 3'd6
    } vss_reg_idx_t;

    typedef struct packed {
        logic [CODE_W-1:0]  low_code;
        logic [CODE_W-1:0]  high_code;
        logic [STEP_W-1:0]  step_size;
        logic [BIAS_W-1:0]  bias_code;
        logic [PPS_W-1:0]   points_per_slope;
        logic [CYC_W-1:0]   cycle_count;
        logic [SCALE_W-1:0] current_scale;
    } vss_cfg_t;

    typedef struct packed {
        logic [WORD_W-1:0]       dac_word;
        logic signed [CUR_W-1:0] current_q;
        logic                    done_res;
        logic                    idle_error;
    } vss_res_t;

endpackage

[rtl/vss_regs.sv]
module vss_regs
    import vss_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output vss_cfg_t          cfg
);

    vss_cfg_t     cfg_reg;
    vss_reg_idx_t idx;
    logic         wr_en;

    assign idx    = vss_reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.low_code         <= '0;
            cfg_reg.high_code        <= CODE_MAX;
            cfg_reg.step_size        <= STEP_W'(256);
            cfg_reg.bias_code        <= BIAS_W'(31);
            cfg_reg.points_per_slope <= '0;
            cfg_reg.cycle_count      <= CYC_W'(1);
            cfg_reg.current_scale    <= '0;
        end else if (wr_en) begin
            case (idx)
                REG_LOW_CODE:      cfg_reg.low_code         <= pwdata[CODE_W-1:0];
                REG_HIGH_CODE:     cfg_reg.high_code        <= pwdata[CODE_W-1:0];
                REG_STEP_SIZE:     cfg_reg.step_size        <= pwdata[STEP_W-1:0];
                REG_BIAS_CODE:     cfg_reg.bias_code        <= pwdata[BIAS_W-1:0];
                REG_POINTS:        cfg_reg.points_per_slope <= pwdata[PPS_W-1:0];
                REG_CYCLE_COUNT:   cfg_reg.cycle_count      <= pwdata[CYC_W-1:0];
                REG_CURRENT_SCALE: cfg_reg.current_scale    <= pwdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_LOW_CODE:      prdata = 32'(cfg_reg.low_code);
            REG_HIGH_CODE:     prdata = 32'(cfg_reg.high_code);
            REG_STEP_SIZE:     prdata = 32'(cfg_reg.step_size);
            REG_BIAS_CODE:     prdata = 32'(cfg_reg.bias_code);
            REG_POINTS:        prdata = 32'(cfg_reg.points_per_slope);
            REG_CYCLE_COUNT:   prdata = 32'(cfg_reg.cycle_count);
            REG_CURRENT_SCALE: prdata = 32'(cfg_reg.current_scale);
            default:           prdata = '0;
        endcase
    end

endmodule

[rtl/vss_step.sv]
module vss_step
    import vss_pkg::*;
#(
    parameter int STEP_FRAC_BITS    = STEP_FRAC_BITS_DEF,
    parameter int POINT_COUNT_WIDTH = POINT_COUNT_WIDTH_DEF,
    parameter int ACC_W             = STEP_W + POINT_COUNT_WIDTH
)
(
    input  vss_cfg_t                      cfg,
    input  logic                          mode,
    input  logic [SAMPLE_W-1:0]           adc_sample,
    input  logic                          running,
    input  logic [SLOPE_W-1:0]            slope,
    input  logic [POINT_COUNT_WIDTH-1:0]  point_idx,
    input  logic [ACC_W-1:0]              acc,
    output logic                          running_next,
    output logic [SLOPE_W-1:0]            slope_next,
    output logic [POINT_COUNT_WIDTH-1:0]  point_idx_next,
    output logic [ACC_W-1:0]              acc_next,
    output vss_res_t                      res
);

    localparam logic [ACC_W:0] ROUND_UP = (ACC_W+1)'((1 << STEP_FRAC_BITS) - 1);

    logic [POINT_COUNT_WIDTH-1:0] pts;
    logic [SLOPE_W-1:0]           total_slopes;
    logic [POINT_COUNT_WIDTH-1:0] pi_inc;
    logic [ACC_W-1:0]             acc_inc;
    logic [SLOPE_W-1:0]           slope_inc;
    logic [SLOPE_W-1:0]           slope_adv;
    logic                         slope_wrap;
    logic                         sweep_end;
    logic                         empty_sweep;

    logic signed [SAMPLE_W:0]     diff;
    logic signed [SCALE_W:0]      scale_s;
    logic signed [CUR_W+1:0]      prod;

    logic [ACC_W-1:0]             whole_dn;
    logic [ACC_W:0]               rise_sum;
    logic [ACC_W:0]               acc_up;
    logic [ACC_W:0]               whole_up;
    logic [CODE_W-1:0]            code;
    logic [WORD_W-1:0]            point_word;

    assign pts          = POINT_COUNT_WIDTH'(cfg.points_per_slope);
    assign total_slopes = {cfg.cycle_count, 1'b0};
    assign empty_sweep  = (pts == '0) || (total_slopes == '0);

    assign diff    = $signed(ADC_MIDPOINT - {1'b0, adc_sample});
    assign scale_s = $signed({1'b0, cfg.current_scale});
    assign prod    = diff * scale_s;

    assign pi_inc     = point_idx + 1'b1;
    assign acc_inc    = acc + ACC_W'(cfg.step_size);
    assign slope_wrap = (pi_inc >= pts) || (pi_inc == '0);
    assign slope_inc  = slope + 1'b1;
    assign slope_adv  = slope_wrap ? slope_inc : slope;

    // point code from the state after this item
    assign whole_dn = acc_next >> STEP_FRAC_BITS;
    assign rise_sum = {1'b0, whole_dn} + (ACC_W+1)'(cfg.low_code);
    assign acc_up   = {1'b0, acc_next} + ROUND_UP;
    assign whole_up = acc_up >> STEP_FRAC_BITS;

    always_comb begin
        if (slope_next[0]) begin
            code = (rise_sum > (ACC_W+1)'(CODE_MAX)) ? CODE_MAX : rise_sum[CODE_W-1:0];
        end else begin
            code = (whole_up > (ACC_W+1)'(cfg.high_code)) ? '0
                 : cfg.high_code - whole_up[CODE_W-1:0];
        end
    end

    assign point_word = {cfg.bias_code, code};
    assign sweep_end  = (slope_adv > total_slopes) || (slope_adv == '0);

    always_comb begin
        running_next   = running;
        slope_next     = slope;
        point_idx_next = point_idx;
        acc_next       = acc;
        if (mode == MODE_START) begin
            slope_next     = FIRST_SLOPE;
            point_idx_next = '0;
            acc_next       = '0;
            running_next   = !empty_sweep;
        end else if (running) begin
            slope_next = slope_adv;
            if (slope_wrap) begin
                point_idx_next = '0;
                acc_next       = '0;
            end else begin
                point_idx_next = pi_inc;
                acc_next       = acc_inc;
            end
            running_next = !sweep_end;
        end
    end

    always_comb begin
        res.dac_word   = ZERO_LEVEL_WORD;
        res.current_q  = '0;
        res.done_res   = 1'b0;
        res.idle_error = 1'b0;
        if (mode == MODE_START) begin
            res.done_res = empty_sweep;
            if (!empty_sweep) begin
                res.dac_word = point_word;
            end
        end else if (!running) begin
            res.idle_error = 1'b1;
        end else begin
            res.current_q = prod[CUR_W-1:0];
            res.done_res  = sweep_end;
            if (!sweep_end) begin
                res.dac_word = point_word;
            end
        end
    end

endmodule

[rtl/voltammetry_staircase_sequencer.sv]
// Throughput: one word per cycle while the output is not stalled; an accepted input
// word passes the input register, one combinational pass (17x25 multiply, step
// accumulator and code clamp) and the output register to be valid on m_tvalid.
// Reset: aresetn synchronous, active low; clears the valid flags of both pipeline stages, the
// sweep state (idle, slope 1, point 0) and the registers to their defaults.
module voltammetry_staircase_sequencer
    import vss_pkg::*;
#(
    parameter int STEP_FRAC_BITS    = STEP_FRAC_BITS_DEF,
    parameter int POINT_COUNT_WIDTH = POINT_COUNT_WIDTH_DEF
)
(
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,   // [15:0] adc_sample
    input  logic              s_tuser,   // [0] mode

    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [63:0]       m_tdata,   // [17:0] dac_word, [57:18] current_q
    output logic              m_tlast,   // done_res
    output logic              m_tuser,   // [0] idle_error

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int ACC_W = STEP_W + POINT_COUNT_WIDTH;

    vss_cfg_t cfg;

    logic                         in_valid_reg;
    logic                         in_mode_reg;
    logic [SAMPLE_W-1:0]          in_sample_reg;
    logic                         out_valid_reg;
    vss_res_t                     out_res_reg;

    logic                         running_reg;
    logic [SLOPE_W-1:0]           slope_reg;
    logic [POINT_COUNT_WIDTH-1:0] point_reg;
    logic [ACC_W-1:0]             acc_reg;

    logic                         running_next;
    logic [SLOPE_W-1:0]           slope_next;
    logic [POINT_COUNT_WIDTH-1:0] point_next;
    logic [ACC_W-1:0]             acc_next;
    vss_res_t                     res_next;

    logic                         advance;
    logic                         s_take;

    vss_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    vss_step #(
        .STEP_FRAC_BITS    (STEP_FRAC_BITS),
        .POINT_COUNT_WIDTH (POINT_COUNT_WIDTH),
        .ACC_W             (ACC_W)
    ) u_step (
        .cfg            (cfg),
        .mode           (in_mode_reg),
        .adc_sample     (in_sample_reg),
        .running        (running_reg),
        .slope          (slope_reg),
        .point_idx      (point_reg),
        .acc            (acc_reg),
        .running_next   (running_next),
        .slope_next     (slope_next),
        .point_idx_next (point_next),
        .acc_next       (acc_next),
        .res            (res_next)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            running_reg   <= 1'b0;
            slope_reg     <= FIRST_SLOPE;
            point_reg     <= '0;
            acc_reg       <= '0;
        end else begin
            if (s_take) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                running_reg   <= running_next;
                slope_reg     <= slope_next;
                point_reg     <= point_next;
                acc_reg       <= acc_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_mode_reg   <= s_tuser;
            in_sample_reg <= s_tdata;
        end
        if (advance) begin
            out_res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_res_reg.current_q, out_res_reg.dac_word};
    assign m_tlast  = out_res_reg.done_res;
    assign m_tuser  = out_res_reg.idle_error;

endmodule

[rtl/vss_checker.sv]
module vss_checker
    import vss_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_done_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[17:0] == ZERO_LEVEL_WORD && !m_tuser)
        else $error("done word is not the zero level");

    a_idle_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[17:0] == ZERO_LEVEL_WORD && m_tdata[57:18] == '0)
        else $error("idle error word carries data");

    a_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && m_tready |-> s_tready)
        else $error("input stalled while output drains");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind voltammetry_staircase_sequencer vss_checker u_vss_checker (.*);
